[design/rsv_pkg.sv]
// Package for the redundant sensor voter: widths, register indexes and reset values.
// No dependencies; imported by redundant_sensor_voter and tb_redundant_sensor_voter.
package rsv_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned NUM_LINKS        = 3;
  localparam int unsigned AGE_W            = 4;
  localparam int unsigned LEVEL_W          = 16;
  localparam int unsigned DIS_W            = 16;
  localparam int unsigned CFG_ADDR_W       = 2;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam int unsigned OUT_TDATA_W      = 40;

  localparam logic [AGE_W-1:0] AGE_MAX           = 4'd15;
  localparam logic [AGE_W-1:0] MAX_AGE_RESET     = 4'd4;
  localparam logic [DIS_W-1:0] DIS_SAT           = 16'hFFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_AGE     = 2'd0,
    CFG_FUSE_MODE   = 2'd1,
    CFG_START_LEVEL = 2'd2
  } cfg_reg_e;

  typedef enum logic [0:0] {
    FUSE_MEDIAN = 1'b0,
    FUSE_MEAN   = 1'b1
  } fuse_mode_e;

endpackage

[design/redundant_sensor_voter.sv]
// Triple redundant sensor voter with per-link staleness tracking.
// Depends on rsv_pkg.
// Throughput: one item per cycle unless the result stream stalls; the pipeline
// (input, freshness, multiply, vote) moves as one.
// The mean of three uses a reciprocal multiply registered before the vote stage.
// Reset: config registers return to defaults, link ages and held values clear to zero;
// the first item loads start_level into the held samples and the last vote. No clearing pass.
module redundant_sensor_voter #(
  parameter int unsigned SAMPLE_WIDTH = rsv_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  // cfg write channel
  input  logic                                           cfg_valid_i,
  output logic                                           cfg_ready_o,
  input  logic [rsv_pkg::CFG_ADDR_W-1:0]                 cfg_index_i,
  input  logic [rsv_pkg::CFG_DATA_W-1:0]                 cfg_data_i,
  // input beat
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // valid_a, sample_a, valid_b, sample_b, valid_c, sample_c, zero pad
  input  logic [((3*(SAMPLE_WIDTH+1)+7)/8)*8-1:0]        s_axis_tdata,
  // result beat
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // voted_level, disagreement, fresh_count, fresh_mask, degraded, zero pad
  output logic [rsv_pkg::OUT_TDATA_W-1:0]                m_axis_tdata
);
  import rsv_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned SUMW   = SW + 2;
  localparam int unsigned DIV3_K = SUMW + 1;
  localparam int unsigned RCPW   = SW + 2;
  localparam int unsigned PRODW  = SUMW + RCPW;
  localparam logic [63:0] DIV3_M64 = ((64'd1 << DIV3_K) + 64'd2) / 64'd3;
  localparam logic [RCPW-1:0] DIV3_M = RCPW'(DIV3_M64);
  localparam logic [SUMW-1:0] DIV3_OFS = SUMW'(3) << (SW - 1);

  function automatic logic signed [SW-1:0] med3(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b,
                                                 input logic signed [SW-1:0] c);
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  // config
  logic [AGE_W-1:0]            max_age_q;
  fuse_mode_e                  fuse_mode_q;
  logic signed [LEVEL_W-1:0]   start_q;
  logic signed [SW-1:0]        start_sw;

  // pipeline control
  logic adv;
  logic s0_v_q, s1_v_q, s2_v_q, out_v_q;

  // stage 0: input register
  logic [NUM_LINKS-1:0]        s0_val_q;
  logic signed [SW-1:0]        s0_smp_q [NUM_LINKS];

  // link state
  logic [AGE_W-1:0]            age_q    [NUM_LINKS];
  logic [AGE_W-1:0]            age_d    [NUM_LINKS];
  logic signed [SW-1:0]        held_q   [NUM_LINKS];
  logic signed [SW-1:0]        held_d   [NUM_LINKS];
  logic                        primed_q;

  // stage 1
  logic [NUM_LINKS-1:0]        s1_mask_d, s1_mask_q;
  logic [1:0]                  s1_cnt_d, s1_cnt_q;
  logic signed [SUMW-1:0]      s1_sum_d, s1_sum_q;
  logic signed [SW-1:0]        s1_f_q   [NUM_LINKS];
  logic                        s1_first_q;

  // stage 2
  logic [NUM_LINKS-1:0]        s2_mask_q;
  logic [1:0]                  s2_cnt_q;
  logic signed [SUMW-1:0]      s2_sum_q;
  logic signed [SW-1:0]        s2_f_q   [NUM_LINKS];
  logic                        s2_first_q;
  logic [PRODW-1:0]            s2_prod_q;
  logic signed [SW-1:0]        s2_med_q;
  logic [SUMW-1:0]             s1_ofs;

  // stage 3 / result
  logic signed [SW-1:0]        vote_d, last_vote_q;
  logic [DIS_W-1:0]            dis_d;
  logic [SW-1:0]               quot;
  logic [LEVEL_W-1:0]          out_vote_q;
  logic [DIS_W-1:0]            out_dis_q;
  logic [1:0]                  out_cnt_q;
  logic [NUM_LINKS-1:0]        out_mask_q;

  assign start_sw    = SW'(start_q);
  assign cfg_ready_o = 1'b1;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv || !s0_v_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q   <= MAX_AGE_RESET;
      fuse_mode_q <= FUSE_MEDIAN;
      start_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_AGE:     max_age_q   <= cfg_data_i[AGE_W-1:0];
        CFG_FUSE_MODE:   fuse_mode_q <= fuse_mode_e'(cfg_data_i[0]);
        CFG_START_LEVEL: start_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: ages, held samples, freshness, sum
  always_comb begin
    logic [NUM_LINKS-1:0] fr;
    logic signed [SW-1:0] base;
    fr       = '0;
    s1_sum_d = '0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      base = primed_q ? held_q[i] : start_sw;
      if (s0_val_q[i]) begin
        age_d[i]  = '0;
        held_d[i] = s0_smp_q[i];
      end else begin
        age_d[i]  = (age_q[i] != AGE_MAX) ? age_q[i] + AGE_W'(1) : age_q[i];
        held_d[i] = base;
      end
      fr[i] = (age_d[i] <= max_age_q);
      if (fr[i]) begin
        s1_sum_d = s1_sum_d + SUMW'(held_d[i]);
      end
    end
    s1_mask_d = fr;
    s1_cnt_d  = 2'({1'b0, fr[0]}) + 2'({1'b0, fr[1]}) + 2'({1'b0, fr[2]});
  end

  assign s1_ofs = SUMW'(s1_sum_q) + DIV3_OFS;

  // stage 3: vote and spread
  always_comb begin
    logic signed [SW:0] diff;
    logic [SW:0]        ad;
    logic [SW:0]        dmax;
    quot = s2_prod_q[DIV3_K +: SW];
    unique case (s2_cnt_q)
      2'd0: vote_d = s2_first_q ? start_sw : last_vote_q;
      2'd1: vote_d = SW'(s2_sum_q);
      2'd2: vote_d = SW'(s2_sum_q >>> 1);
      2'd3: vote_d = (fuse_mode_q == FUSE_MEAN) ? $signed({~quot[SW-1], quot[SW-2:0]})
                                                : s2_med_q;
      default: vote_d = last_vote_q;
    endcase
    dmax = '0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      diff = {s2_f_q[i][SW-1], s2_f_q[i]} - {vote_d[SW-1], vote_d};
      ad   = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
      if (s2_mask_q[i] && (ad > dmax)) begin
        dmax = ad;
      end
    end
    dis_d = (|(dmax >> DIS_W)) ? DIS_SAT : DIS_W'(dmax);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q      <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      primed_q    <= 1'b0;
      last_vote_q <= '0;
      for (int i = 0; i < NUM_LINKS; i++) begin
        age_q[i]  <= '0;
        held_q[i] <= '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        s0_v_q <= 1'b1;
      end else if (adv) begin
        s0_v_q <= 1'b0;
      end
      if (adv) begin
        s1_v_q  <= s0_v_q;
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
        if (s0_v_q) begin
          primed_q <= 1'b1;
          for (int i = 0; i < NUM_LINKS; i++) begin
            age_q[i]  <= age_d[i];
            held_q[i] <= held_d[i];
          end
        end
        if (s2_v_q) begin
          last_vote_q <= vote_d;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int i = 0; i < NUM_LINKS; i++) begin
        s0_val_q[i] <= s_axis_tdata[i*(SW+1)];
        s0_smp_q[i] <= s_axis_tdata[i*(SW+1)+1 +: SW];
      end
    end
    if (adv) begin
      s1_mask_q  <= s1_mask_d;
      s1_cnt_q   <= s1_cnt_d;
      s1_sum_q   <= s1_sum_d;
      s1_first_q <= !primed_q;
      for (int i = 0; i < NUM_LINKS; i++) begin
        s1_f_q[i] <= held_d[i];
        s2_f_q[i] <= s1_f_q[i];
      end
      s2_mask_q  <= s1_mask_q;
      s2_cnt_q   <= s1_cnt_q;
      s2_sum_q   <= s1_sum_q;
      s2_first_q <= s1_first_q;
      s2_prod_q  <= s1_ofs * DIV3_M;
      s2_med_q   <= med3(s1_f_q[0], s1_f_q[1], s1_f_q[2]);
      out_vote_q <= LEVEL_W'(vote_d);
      out_dis_q  <= dis_d;
      out_cnt_q  <= s2_cnt_q;
      out_mask_q <= s2_mask_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, (out_cnt_q != 2'd3), out_mask_q, out_cnt_q,
                          out_dis_q, out_vote_q};

`ifndef ASSERT_OFF
  a_cnt_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (32'(out_cnt_q) == $countones(out_mask_q)))
    else $error("fresh count disagrees with fresh mask");

  a_no_fresh_no_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_mask_q == '0)) |-> (out_dis_q == '0))
    else $error("spread reported with no fresh link");

  a_primed_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s0_v_q) |=> primed_q)
    else $error("link state not primed after first item");

  a_pipe_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_v_q) |=> out_v_q)
    else $error("result lost between vote stage and output");
`endif

endmodule

[sim/tb_redundant_sensor_voter.sv]
// Self-checking testbench for redundant_sensor_voter: drives sensor ticks over the input
// stream, predicts every vote in-line and checks the result stream beat by beat.
// Depends on rsv_pkg and redundant_sensor_voter.
module tb_redundant_sensor_voter;
  timeunit 1ns;
  timeprecision 1ps;

  import rsv_pkg::*;

  localparam int unsigned SW        = SAMPLE_WIDTH_DEF;
  localparam int unsigned IN_W      = ((3 * (SW + 1) + 7) / 8) * 8;
  localparam int          LATENCY   = 3;
  localparam int          LONG_HOLD = 300;
  localparam int          CYCLE_CAP = 200000;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [2:0]          valid;
    logic [2:0][SW-1:0]  sample;
  } tick_t;

  // highest field first, matching the result tdata layout
  typedef struct packed {
    logic                degraded;
    logic [2:0]          mask;
    logic [1:0]          count;
    logic [DIS_W-1:0]    dis;
    logic [LEVEL_W-1:0]  level;
  } vote_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  redundant_sensor_voter #(.SAMPLE_WIDTH(SW)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // voter state as seen by the predictor
  logic [AGE_W-1:0]         max_age_q     = MAX_AGE_RESET;
  fuse_mode_e               fuse_q        = FUSE_MEDIAN;
  logic signed [LEVEL_W-1:0] start_level_q = '0;
  logic signed [SW-1:0]     held_sample [3];
  logic [AGE_W-1:0]         link_age [3];
  logic signed [LEVEL_W-1:0] last_vote     = '0;
  logic                     primed        = 1'b0;

  tick_t pending_ticks [$];
  vote_t expected_votes [$];
  tick_t tick_on_bus;
  int    outage_left [3];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int ticks_sent     = 0;
  int votes_checked  = 0;
  int settings_run   = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  initial begin
    for (int i = 0; i < 3; i++) begin
      held_sample[i] = '0;
      link_age[i]    = '0;
      outage_left[i] = 0;
    end
  end

  function automatic int floor_div(int num, int den);
    int q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic vote_t predict_vote(tick_t t);
    int    fresh_val [3];
    int    nf;
    int    vote;
    int    dev;
    int    dmax;
    int    lo;
    int    hi;
    int    i;
    vote_t r;
    nf   = 0;
    dmax = 0;
    r    = '0;
    if (!primed) begin
      for (i = 0; i < 3; i++) held_sample[i] = start_level_q;
      last_vote = start_level_q;
      primed    = 1'b1;
    end
    for (i = 0; i < 3; i++) begin
      if (t.valid[i]) begin
        held_sample[i] = t.sample[i];
        link_age[i]    = '0;
      end else if (link_age[i] != AGE_MAX) begin
        link_age[i] = link_age[i] + 1'b1;
      end
      if (link_age[i] <= max_age_q) begin
        fresh_val[nf] = held_sample[i];
        nf++;
        r.mask[i] = 1'b1;
      end
    end
    if (nf == 0) begin
      vote = last_vote;
    end else if (fuse_q == FUSE_MEAN) begin
      vote = 0;
      for (i = 0; i < nf; i++) vote += fresh_val[i];
      vote = floor_div(vote, nf);
    end else if (nf == 1) begin
      vote = fresh_val[0];
    end else if (nf == 2) begin
      vote = floor_div(fresh_val[0] + fresh_val[1], 2);
    end else begin
      lo = (fresh_val[0] < fresh_val[1]) ? fresh_val[0] : fresh_val[1];
      hi = (fresh_val[0] < fresh_val[1]) ? fresh_val[1] : fresh_val[0];
      vote = (fresh_val[2] <= lo) ? lo : (fresh_val[2] >= hi) ? hi : fresh_val[2];
    end
    last_vote = vote[LEVEL_W-1:0];
    for (i = 0; i < nf; i++) begin
      dev = fresh_val[i] - vote;
      if (dev < 0) dev = -dev;
      if (dev > dmax) dmax = dev;
    end
    r.level    = vote[LEVEL_W-1:0];
    r.dis      = (dmax > 65535) ? DIS_SAT : dmax[DIS_W-1:0];
    r.count    = nf[1:0];
    r.degraded = (nf < 3);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_tick(tick_t t);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      d[i*(SW+1)]        = t.valid[i];
      d[i*(SW+1)+1 +: SW] = t.sample[i];
    end
    return d;
  endfunction

  function automatic tick_t mk_tick(logic [2:0] v, logic [SW-1:0] a, logic [SW-1:0] b,
                                    logic [SW-1:0] c);
    tick_t t;
    t.valid  = v;
    t.sample = {c, b, a};
    return t;
  endfunction

  // links drop out now and then for long runs so ages climb to saturation
  function automatic tick_t rand_tick(int vpct);
    tick_t         t;
    logic [SW-1:0] base;
    int            i;
    base = SW'($urandom);
    for (i = 0; i < 3; i++) begin
      if (outage_left[i] > 0) begin
        outage_left[i]--;
        t.valid[i] = 1'b0;
      end else if ($urandom_range(99) < 3) begin
        outage_left[i] = $urandom_range(24);
        t.valid[i] = 1'b0;
      end else begin
        t.valid[i] = ($urandom_range(99) < vpct);
      end
      case ($urandom_range(3))
        0: t.sample[i] = SW'($urandom);
        1: begin
          case ($urandom_range(3))
            0: t.sample[i] = {1'b1, {(SW-1){1'b0}}};
            1: t.sample[i] = {1'b0, {(SW-1){1'b1}}};
            2: t.sample[i] = '0;
            default: t.sample[i] = '1;
          endcase
        end
        default: t.sample[i] = base + SW'($urandom_range(64)) - SW'(32);
      endcase
    end
    return t;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_votes.push_back(predict_vote(tick_on_bus));
        ticks_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_on_bus = pending_ticks.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_tick(tick_on_bus);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure, with a long hold-off counted here on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    vote_t got;
    vote_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = vote_t'(m_axis_tdata[$bits(vote_t)-1:0]);
      if (expected_votes.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result beat, expected none, actual %0h", $time, got);
      end else begin
        want = expected_votes.pop_front();
        votes_checked++;
        check_field("voted_level", want.level, got.level);
        check_field("disagreement", want.dis, got.dis);
        check_field("fresh_count", 16'(want.count), 16'(got.count));
        check_field("fresh_mask", 16'(want.mask), 16'(got.mask));
        check_field("degraded", 16'(want.degraded), 16'(got.degraded));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t ns: timeout, %0d votes still outstanding", $time, expected_votes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAX_AGE:     max_age_q     = val[AGE_W-1:0];
      CFG_FUSE_MODE:   fuse_q        = fuse_mode_e'(val[0]);
      CFG_START_LEVEL: start_level_q = val;
      default: ;
    endcase
  endtask

  // sampled away from the rising edge so the driver's updates have settled
  task automatic wait_drained();
    while (pending_ticks.size() > 0 || s_axis_tvalid || expected_votes.size() > 0)
      @(negedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic run_phase(input int age, input int fuse, input int send_pct,
                           input int recv_pct, input int n, input int vpct, input bit long_hold);
    wait_drained();
    write_reg(CFG_MAX_AGE, {12'($urandom), 4'(age)});
    write_reg(CFG_FUSE_MODE, {15'($urandom), 1'(fuse)});
    if ($urandom_range(1)) write_reg(CFG_START_LEVEL, 16'($urandom));
    if ($urandom_range(1)) write_reg(CFG_UNUSED_IDX, 16'($urandom));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    settings_run++;
    if (long_hold) hold_requests++;
    repeat (n) pending_ticks.push_back(rand_tick(vpct));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_START_LEVEL, 16'h8000);
    write_reg(CFG_UNUSED_IDX, 16'h1234);
    write_reg(CFG_MAX_AGE, 16'hFFF4);
    write_reg(CFG_FUSE_MODE, 16'hFFFE);
    settings_run++;

    // first tick loads the start level; then extremes, one/two/three fresh, all stale
    pending_ticks.push_back(mk_tick(3'b000, 16'h0000, 16'h0000, 16'h0000));
    pending_ticks.push_back(mk_tick(3'b001, 16'h7FFF, 16'h0000, 16'h0000));
    pending_ticks.push_back(mk_tick(3'b111, 16'h8000, 16'h7FFF, 16'h0000));
    pending_ticks.push_back(mk_tick(3'b111, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_ticks.push_back(mk_tick(3'b111, 16'h8000, 16'h8000, 16'h7FFF));
    repeat (5) pending_ticks.push_back(mk_tick(3'b001, 16'h8000, 16'hAAAA, 16'h5555));
    pending_ticks.push_back(mk_tick(3'b011, 16'h8000, 16'h7FFF, 16'hFFFF));
    repeat (6) pending_ticks.push_back(mk_tick(3'b000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    wait_drained();

    write_reg(CFG_FUSE_MODE, 16'h0001);
    write_reg(CFG_MAX_AGE, 16'h0000);
    settings_run++;
    pending_ticks.push_back(mk_tick(3'b111, 16'h8000, 16'h8000, 16'h8001));
    pending_ticks.push_back(mk_tick(3'b011, 16'h7FFF, 16'h7FFE, 16'h0000));
    pending_ticks.push_back(mk_tick(3'b000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_ticks.push_back(mk_tick(3'b100, 16'h0000, 16'h0000, 16'hFFFB));
    pending_ticks.push_back(mk_tick(3'b111, 16'h8000, 16'h7FFF, 16'hFFFF));
    pending_ticks.push_back(mk_tick(3'b101, 16'hFFFF, 16'h0000, 16'h0000));

    //         age fuse send recv items valid% hold
    run_phase(4,  0, 0,  0,  200, 80, 1'b0);
    run_phase(15, 1, 72, 0,  200, 20, 1'b0);
    run_phase(0,  0, 0,  72, 200, 60, 1'b0);
    run_phase(14, 1, 31, 31, 200, 30, 1'b0);
    run_phase(7,  0, 0,  0,  150, 70, 1'b1);
    run_phase(15, 0, 31, 31, 150, 15, 1'b0);
    run_phase(1,  1, 0,  0,  150, 50, 1'b0);
    wait_drained();

    $display("%0d sensor ticks sent, %0d votes checked over %0d register settings",
             ticks_sent, votes_checked, settings_run);
    $display("(median and mean fusion, fresh ages 0 to 15, stale links and saturated ages)");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
